// File: hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants for the stepper tone sequencer: register indexes, reset
// values, phase codes and the note interval table.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int SCALE_STEPS = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_HOME_INTERVAL   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MS_INTERVAL     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PLAY_CYCLES     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REST_TICKS      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_REST_TICKS = 3'd4;

   localparam logic [15:0] RST_HOME_INTERVAL   = 16'd2032;
   localparam logic [15:0] RST_MS_INTERVAL     = 16'd16000;
   localparam logic [31:0] RST_PLAY_CYCLES     = 32'd12800000;
   localparam logic [15:0] RST_REST_TICKS      = 16'd200;
   localparam logic [15:0] RST_LONG_REST_TICKS = 16'd1000;

   localparam logic [1:0] PHASE_HOME_PENDING = 2'd0;
   localparam logic [1:0] PHASE_HOMING       = 2'd1;
   localparam logic [1:0] PHASE_REST         = 2'd2;
   localparam logic [1:0] PHASE_PLAY         = 2'd3;

   typedef logic [15:0] interval_type;

   // Scale intervals, already divided by eight.
   localparam interval_type NOTE_TABLE [8] = '{
      16'd7644, 16'd6810, 16'd6067, 16'd5726,
      16'd5102, 16'd4545, 16'd4049, 16'd3822
   };

   // Notes past the eighth table entry have a zero interval.
   function automatic interval_type note_ivl(input logic [3:0] idx);
      interval_type ivl;
      ivl = '0;
      if (idx < 4'd8) begin
         ivl = NOTE_TABLE[idx[2:0]];
      end
      return ivl;
   endfunction

endpackage

// File: hw/rtl/stepper_tone_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_tone_sequencer
// Plays a scale on a stepper motor, one sequencer step per timer tick.
// ----------------------------------------------------------------------------
// Each req beat is one step-timer tick carrying the minimum-limit switch
// level. Each tick produces exactly one rsp beat with the motor enable, the
// direction, the step interval in force, whether the interval was reloaded on
// this tick, and the current phase.
// The whole tick update is one pass of combinational logic into the state
// registers, so a rsp beat appears the cycle after its req beat is taken and
// a new req beat can be taken every cycle without req_stall. The rsp side is a
// single output register: req_stall rises only while a rsp beat is waiting and
// rsp_stall is high; a stalled receiver holds the sequencer and loses no tick.
// Reset (synchronous, active high) restores the register defaults, clears the
// output register and arms homing: the first tick starts homing toward the
// minimum limit. After homing come a long rest, the eight notes each followed
// by a short rest, and then homing again.
// The csr port writes a register at every clock edge with csr_wr_en high;
// indexes past the last register are ignored. Write only while idle.
// ----------------------------------------------------------------------------
module stepper_tone_sequencer
   import sts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_at_min_limit,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_motor_on,
   output logic                  rsp_dir_positive,
   output logic [15:0]           rsp_step_interval,
   output logic                  rsp_interval_loaded,
   output logic [1:0]            rsp_phase,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [15:0] home_interval_ff;
   logic [15:0] ms_interval_ff;
   logic [31:0] play_cycles_ff;
   logic [15:0] rest_ticks_ff;
   logic [15:0] long_rest_ticks_ff;

   logic         home_pending_ff, home_pending_in;
   logic         homing_active_ff, homing_active_in;
   logic [3:0]   note_index_ff, note_index_in;
   logic [15:0]  rest_left_ff, rest_left_in;
   logic [31:0]  play_left_ff, play_left_in;
   logic         motor_enabled_ff, motor_enabled_in;
   logic         direction_up_ff, direction_up_in;
   interval_type current_interval_ff, current_interval_in;
   logic         loaded_ff, loaded_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic         req_accept;
   interval_type ivl;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      home_pending_in     = home_pending_ff;
      homing_active_in    = homing_active_ff;
      note_index_in       = note_index_ff;
      rest_left_in        = rest_left_ff;
      play_left_in        = play_left_ff;
      motor_enabled_in    = motor_enabled_ff;
      direction_up_in     = direction_up_ff;
      current_interval_in = current_interval_ff;
      loaded_in           = 1'b0;
      ivl                 = '0;

      if (home_pending_ff) begin
         home_pending_in     = 1'b0;
         direction_up_in     = 1'b0;
         motor_enabled_in    = 1'b1;
         current_interval_in = home_interval_ff;
         loaded_in           = 1'b1;
         homing_active_in    = 1'b1;
      end else if (homing_active_ff) begin
         if (req_at_min_limit) begin
            homing_active_in    = 1'b0;
            note_index_in       = '0;
            play_left_in        = '0;
            rest_left_in        = long_rest_ticks_ff;
            direction_up_in     = 1'b1;
            motor_enabled_in    = 1'b0;
            current_interval_in = ms_interval_ff;
            loaded_in           = 1'b1;
         end
      end else begin
         if (rest_left_ff != '0) begin
            rest_left_in = rest_left_ff - 16'd1;
            if (rest_left_in == '0) begin
               if (note_index_ff >= 4'(SCALE_STEPS)) begin
                  note_index_in   = '0;
                  home_pending_in = 1'b1;
               end else begin
                  motor_enabled_in    = 1'b1;
                  current_interval_in = note_ivl(note_index_ff);
                  loaded_in           = 1'b1;
                  play_left_in        = play_cycles_ff;
               end
            end
         end
         // A note that starts on this tick is already counted down here.
         if (play_left_in != '0) begin
            ivl = note_ivl(note_index_in);
            if (play_left_in > {16'd0, ivl}) begin
               play_left_in = play_left_in - {16'd0, ivl};
            end else begin
               play_left_in        = '0;
               rest_left_in        = rest_ticks_ff;
               motor_enabled_in    = 1'b0;
               current_interval_in = ms_interval_ff;
               loaded_in           = 1'b1;
               note_index_in       = note_index_in + 4'd1;
            end
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_interval_ff   <= RST_HOME_INTERVAL;
         ms_interval_ff     <= RST_MS_INTERVAL;
         play_cycles_ff     <= RST_PLAY_CYCLES;
         rest_ticks_ff      <= RST_REST_TICKS;
         long_rest_ticks_ff <= RST_LONG_REST_TICKS;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_HOME_INTERVAL:   home_interval_ff   <= csr_wr_data[15:0];
            CSR_MS_INTERVAL:     ms_interval_ff     <= csr_wr_data[15:0];
            CSR_PLAY_CYCLES:     play_cycles_ff     <= csr_wr_data[31:0];
            CSR_REST_TICKS:      rest_ticks_ff      <= csr_wr_data[15:0];
            CSR_LONG_REST_TICKS: long_rest_ticks_ff <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_pending_ff     <= 1'b1;
         homing_active_ff    <= 1'b0;
         note_index_ff       <= '0;
         rest_left_ff        <= '0;
         play_left_ff        <= '0;
         motor_enabled_ff    <= 1'b0;
         direction_up_ff     <= 1'b1;
         current_interval_ff <= RST_MS_INTERVAL;
         loaded_ff           <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            home_pending_ff     <= home_pending_in;
            homing_active_ff    <= homing_active_in;
            note_index_ff       <= note_index_in;
            rest_left_ff        <= rest_left_in;
            play_left_ff        <= play_left_in;
            motor_enabled_ff    <= motor_enabled_in;
            direction_up_ff     <= direction_up_in;
            current_interval_ff <= current_interval_in;
            loaded_ff           <= loaded_in;
         end
      end
   end

   // The state only moves on an accepted tick, so it doubles as the
   // held rsp payload.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motor_on        = motor_enabled_ff;
   assign rsp_dir_positive    = direction_up_ff;
   assign rsp_step_interval   = current_interval_ff;
   assign rsp_interval_loaded = loaded_ff;

   always_comb begin
      if (home_pending_ff) begin
         rsp_phase = PHASE_HOME_PENDING;
      end else if (homing_active_ff) begin
         rsp_phase = PHASE_HOMING;
      end else if (play_left_ff != '0) begin
         rsp_phase = PHASE_PLAY;
      end else begin
         rsp_phase = PHASE_REST;
      end
   end

endmodule

// File: hw/rtl/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the stepper tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker
   import sts_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_motor_on,
   input logic                  rsp_dir_positive,
   input logic [15:0]           rsp_step_interval,
   input logic                  rsp_interval_loaded,
   input logic [1:0]            rsp_phase
);

   // A waiting beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_step_interval)
         && $stable(rsp_phase) && $stable(rsp_interval_loaded))
      else $error("sts: stalled rsp beat changed");

   // Every accepted tick yields a beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("sts: accepted tick produced no rsp beat");

   // The tick that starts homing drives the motor toward the limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PHASE_HOMING && rsp_interval_loaded
         |-> rsp_motor_on && !rsp_dir_positive)
      else $error("sts: homing start with wrong motor setting");

   // A sounding note always has the motor enabled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PHASE_PLAY |-> rsp_motor_on && rsp_dir_positive)
      else $error("sts: playing with motor off");

   // Homing is armed only out of a rest, with the motor off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PHASE_HOME_PENDING |-> !rsp_motor_on)
      else $error("sts: home pending with motor on");

endmodule

bind stepper_tone_sequencer sts_checker u_sts_checker (.*);
